FILE: rtl/u8d_pkg.sv
// Shared types, constants and lead-byte decode functions for the UTF-8 decoder.
`default_nettype none

package u8d_pkg;

  localparam int CP_W = 21;

  // Lead byte patterns and masks
  localparam logic [7:0] ASCII_MASK  = 8'b1000_0000;
  localparam logic [7:0] LEAD2_MASK  = 8'b1110_0000;
  localparam logic [7:0] LEAD2_PAT   = 8'b1100_0000;
  localparam logic [7:0] LEAD3_MASK  = 8'b1111_0000;
  localparam logic [7:0] LEAD3_PAT   = 8'b1110_0000;
  localparam logic [7:0] LEAD4_MASK  = 8'b1111_1000;
  localparam logic [7:0] LEAD4_PAT   = 8'b1111_0000;
  localparam logic [7:0] BITS1_MASK  = 8'b0111_1111;
  localparam logic [7:0] BITS2_MASK  = 8'b0001_1111;
  localparam logic [7:0] BITS3_MASK  = 8'b0000_1111;
  localparam logic [7:0] BITS4_MASK  = 8'b0000_0111;
  localparam logic [7:0] CONT_MASK   = 8'b0011_1111;

  // Sequence length codes
  localparam logic [2:0] LEN_BAD = 3'd0;
  localparam logic [2:0] LEN_1   = 3'd1;
  localparam logic [2:0] LEN_2   = 3'd2;
  localparam logic [2:0] LEN_3   = 3'd3;
  localparam logic [2:0] LEN_4   = 3'd4;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       end_of_string;
  } in_item_t;

  typedef struct packed {
    logic [CP_W-1:0] codepoint;
    logic            last_of_run;
  } out_item_t;

  // Results of one input byte, as held in the queue
  typedef struct packed {
    logic            pair;
    logic [CP_W-1:0] cp0;
    logic [CP_W-1:0] cp1;
  } res_entry_t;

  // Sequence length opened by a lead byte
  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] len;
    len = LEN_BAD;
    if ((b & ASCII_MASK) == 8'h00)           len = LEN_1;
    else if ((b & LEAD2_MASK) == LEAD2_PAT)  len = LEN_2;
    else if ((b & LEAD3_MASK) == LEAD3_PAT)  len = LEN_3;
    else if ((b & LEAD4_MASK) == LEAD4_PAT)  len = LEN_4;
    return len;
  endfunction

  // Payload bits of a lead byte
  function automatic logic [6:0] lead_bits(input logic [7:0] b);
    logic [7:0] m;
    m = 8'h00;
    if ((b & ASCII_MASK) == 8'h00)           m = b & BITS1_MASK;
    else if ((b & LEAD2_MASK) == LEAD2_PAT)  m = b & BITS2_MASK;
    else if ((b & LEAD3_MASK) == LEAD3_PAT)  m = b & BITS3_MASK;
    else if ((b & LEAD4_MASK) == LEAD4_PAT)  m = b & BITS4_MASK;
    return m[6:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/u8d_front.sv
// Front end: classifies each byte, tracks the open sequence, forms its results.
`default_nettype none

module u8d_front
  import u8d_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire in_item_t   item,
  output res_entry_t      entry,
  output logic            entry_valid
);

  logic [1:0]      bytes_remaining, bytes_remaining_next;
  logic [CP_W-1:0] accumulator, accumulator_next;
  logic [7:0]      held0, held0_next;
  logic [1:0]      held_count, held_count_next;

  logic [7:0]      b;
  logic            eos;
  logic [2:0]      len;
  logic [6:0]      bits;
  logic [CP_W-1:0] acc_sh;
  logic [1:0]      rem_dec;
  logic [2:0]      t0_len;
  logic [6:0]      t0_bits;
  logic [1:0]      n_res;

  assign b   = item.byte_in;
  assign eos = item.end_of_string;
  assign len = lead_len(b);
  assign bits = lead_bits(b);
  assign acc_sh = {accumulator[CP_W-7:0], b[5:0]};
  assign rem_dec = bytes_remaining - 2'd1;
  assign t0_len = lead_len(held0);
  assign t0_bits = lead_bits(held0);

  // Next state and results for the byte on the input
  always_comb begin
    bytes_remaining_next = bytes_remaining;
    accumulator_next     = accumulator;
    held0_next           = held0;
    held_count_next      = held_count;
    n_res                = 2'd0;
    entry.cp0            = '0;
    entry.cp1            = '0;
    if (bytes_remaining == 2'd0) begin
      held_count_next = 2'd0;
      if (len == LEN_1) begin
        n_res     = 2'd1;
        entry.cp0 = {{(CP_W-7){1'b0}}, bits};
      end else if (len != LEN_BAD && !eos) begin
        bytes_remaining_next = 2'(len - 3'd1);
        accumulator_next     = {{(CP_W-7){1'b0}}, bits};
      end else begin
        accumulator_next = '0;
      end
    end else begin
      accumulator_next     = acc_sh;
      bytes_remaining_next = rem_dec;
      if (rem_dec == 2'd0) begin
        n_res            = 2'd1;
        entry.cp0        = acc_sh;
        accumulator_next = '0;
        held_count_next  = 2'd0;
      end else if (eos) begin
        // string cut short: retry the held byte and this one as leads
        if (held_count == 2'd0) begin
          if (len == LEN_1) begin
            n_res     = 2'd1;
            entry.cp0 = {{(CP_W-7){1'b0}}, bits};
          end
        end else if (t0_len == LEN_1) begin
          entry.cp0 = {{(CP_W-7){1'b0}}, t0_bits};
          if (len == LEN_1) begin
            n_res     = 2'd2;
            entry.cp1 = {{(CP_W-7){1'b0}}, bits};
          end else begin
            n_res = 2'd1;
          end
        end else if (t0_len == LEN_2) begin
          n_res     = 2'd1;
          entry.cp0 = {{(CP_W-11){1'b0}}, t0_bits[4:0], b[5:0]};
        end else if (len == LEN_1) begin
          n_res     = 2'd1;
          entry.cp0 = {{(CP_W-7){1'b0}}, bits};
        end
        bytes_remaining_next = 2'd0;
        accumulator_next     = '0;
        held_count_next      = 2'd0;
      end else if (held_count < 2'd2) begin
        // only the first held byte is ever replayed
        if (held_count == 2'd0) held0_next = b;
        held_count_next = held_count + 2'd1;
      end
    end
    entry.pair  = (n_res == 2'd2);
    entry_valid = (n_res != 2'd0);
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_remaining <= 2'd0;
      accumulator     <= '0;
      held_count      <= 2'd0;
    end else if (accept) begin
      bytes_remaining <= bytes_remaining_next;
      accumulator     <= accumulator_next;
      held_count      <= held_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) held0 <= held0_next;
  end

endmodule

`default_nettype wire

FILE: rtl/u8d_queue.sv
// Result queue between the front end and the output stage.
`default_nettype none

module u8d_queue
  import u8d_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       wr_en,
  input  wire res_entry_t wr_data,
  input  wire logic       rd_en,
  output res_entry_t      rd_data,
  output logic            full,
  output logic            empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  res_entry_t       mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  // Storage write
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_ptr] <= wr_data;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      if (rd_en) rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      if (wr_en && !rd_en)      count <= count + CNT_W'(1);
      else if (rd_en && !wr_en) count <= count - CNT_W'(1);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/u8d_back.sv
// Output stage: hands out the one or two code points of each queue entry.
`default_nettype none

module u8d_back
  import u8d_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire res_entry_t head,
  input  wire logic       head_empty,
  input  wire logic       pop,
  output logic            deq,
  output out_item_t       result
);

  logic sel;
  logic fire;

  assign fire = pop && !head_empty;
  assign deq  = fire && (!head.pair || sel);

  // Select the half of the entry on show
  always_comb begin
    result.codepoint   = sel ? head.cp1 : head.cp0;
    result.last_of_run = !head.pair || sel;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sel <= 1'b0;
    end else if (fire) begin
      sel <= head.pair && !sel;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/utf8_byte_stream_decoder.sv
// UTF-8 byte stream decoder: one byte per transfer in, one code point per transfer out.
// A result enters the queue when its byte is taken and is on the output once all
// earlier entries are popped. Throughput: one byte per cycle while full is low; each
// result takes one output transfer, so a two-result byte takes two, absorbed by the queue.
// full rises only when all QUEUE_DEPTH queue entries hold pending results.
// Reset: synchronous; clears sequence state, queue pointers and output select.
`default_nettype none

module utf8_byte_stream_decoder
  import u8d_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  output logic           full,
  input  wire in_item_t  item,
  output logic           empty,
  input  wire logic      pop,
  output out_item_t      result
);

  logic       accept;
  res_entry_t entry;
  logic       entry_valid;
  res_entry_t head;
  logic       deq;

  assign accept = push && !full;

  // Byte classification and sequence tracking
  u8d_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .item        (item),
    .entry       (entry),
    .entry_valid (entry_valid)
  );

  // Decoupling queue
  u8d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (accept && entry_valid),
    .wr_data (entry),
    .rd_en   (deq),
    .rd_data (head),
    .full    (full),
    .empty   (empty)
  );

  // Result delivery
  u8d_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_empty (empty),
    .pop        (pop),
    .deq        (deq),
    .result     (result)
  );

endmodule

`default_nettype wire
